FILE: rtl/c8ic_pkg.sv
// Shared types, codes and constants for the CHIP-8 instruction core.
`timescale 1ns / 1ps
package c8ic_pkg;

    localparam int unsigned ROWS       = 32;
    localparam int unsigned ROW_W      = 5;
    localparam int unsigned FONT_BYTES = 80;
    localparam logic [11:0] START_RESET = 12'h200;

    // Item operations
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_ROW  = 2'd3;

    // Opcode groups (top nibble)
    localparam logic [3:0] G_SYS  = 4'h0;
    localparam logic [3:0] G_JP   = 4'h1;
    localparam logic [3:0] G_CALL = 4'h2;
    localparam logic [3:0] G_SE   = 4'h3;
    localparam logic [3:0] G_SNE  = 4'h4;
    localparam logic [3:0] G_SER  = 4'h5;
    localparam logic [3:0] G_LD   = 4'h6;
    localparam logic [3:0] G_ADD  = 4'h7;
    localparam logic [3:0] G_ALU  = 4'h8;
    localparam logic [3:0] G_SNER = 4'h9;
    localparam logic [3:0] G_LDI  = 4'hA;
    localparam logic [3:0] G_JPV  = 4'hB;
    localparam logic [3:0] G_RND  = 4'hC;
    localparam logic [3:0] G_DRW  = 4'hD;
    localparam logic [3:0] G_KEY  = 4'hE;
    localparam logic [3:0] G_MISC = 4'hF;

    localparam logic [15:0] OPC_CLS = 16'h00E0;
    localparam logic [15:0] OPC_RET = 16'h00EE;

    // 8XYN sub-operations
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    // EXNN and FXNN low bytes
    localparam logic [7:0] K_SKP  = 8'h9E;
    localparam logic [7:0] K_SKNP = 8'hA1;
    localparam logic [7:0] F_GDT  = 8'h07;
    localparam logic [7:0] F_WKEY = 8'h0A;
    localparam logic [7:0] F_SDT  = 8'h15;
    localparam logic [7:0] F_SST  = 8'h18;
    localparam logic [7:0] F_ADDI = 8'h1E;
    localparam logic [7:0] F_FONT = 8'h29;
    localparam logic [7:0] F_BCD  = 8'h33;
    localparam logic [7:0] F_STR  = 8'h55;
    localparam logic [7:0] F_LDR  = 8'h65;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FETCH1, S_FETCH2, S_RDX, S_RDY, S_EXEC, S_WRF,
        S_DRAW_RD, S_DRAW_WR, S_BCD, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR,
        S_DONE_ROW
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [11:0] address;
        logic [7:0]  data_byte;
        logic [15:0] key_mask;
        logic [7:0]  random_byte;
    } in_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] executed_opcode;
        logic        status;
        logic        draw_flag;
        logic        sound_on;
        logic [63:0] display_row;
    } out_t;

    // Built-in hex font, five bytes per digit
    function automatic logic [7:0] font_byte(input logic [6:0] idx);
        logic [7:0] b;
        case (idx)
            7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22,
            7'd25, 7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42,
            7'd44, 7'd45, 7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70,
            7'd72, 7'd74, 7'd75, 7'd77: b = 8'hF0;
            7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46,
            7'd51, 7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68:
                b = 8'h90;
            7'd5, 7'd7, 7'd8, 7'd37: b = 8'h20;
            7'd6: b = 8'h60;
            7'd9: b = 8'h70;
            7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48:
                b = 8'h10;
            7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76,
            7'd78, 7'd79:
                b = 8'h80;
            7'd38, 7'd39: b = 8'h40;
            7'd55, 7'd57, 7'd59, 7'd65, 7'd69: b = 8'hE0;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/c8ic_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module c8ic_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/chip8_instruction_core.sv
// CHIP-8 instruction core: sequencer around main memory, register file and display RAMs.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_ready   | in_data  (c8ic_pkg::in_t)
//  out     | out | out_valid / out_ready | out_data (c8ic_pkg::out_t)
//  cfg     | in  | cfg_valid / cfg_ready | cfg_data (start address, also loads the PC)
//
// Load, tick and row read go to the final state; an instruction fetches two bytes,
// reads VX and VY and executes, writes VF when it sets the flag, reads then writes each
// DXYN sprite row and FX55/FX65 register, and writes each FX33 digit, since each memory
// takes one read and one write per cycle. After reset a clearing pass writes MEMORY_BYTES
// bytes of font and zeros before the first transaction is accepted. The result register
// frees the sequencer; a stalled output holds the next result in its final state.
`timescale 1ns / 1ps
module chip8_instruction_core #(
    parameter int unsigned MEMORY_BYTES = 4096,
    parameter int unsigned STACK_DEPTH  = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  c8ic_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output c8ic_pkg::out_t  out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [11:0]     cfg_data
);
    import c8ic_pkg::*;

    localparam int unsigned AW  = $clog2(MEMORY_BYTES);
    localparam int unsigned SPW = $clog2(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);
    localparam logic [AW-1:0]  MEM_LAST = AW'(MEMORY_BYTES - 1);

    // Control registers
    state_t         state_reg, state_next;
    logic [11:0]    pc_reg, pc_next;
    logic [15:0]    i_reg, i_next;
    logic [SPW-1:0] sp_reg, sp_next;
    logic [7:0]     dt_reg, dt_next;
    logic [7:0]     st_reg, st_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic           out_valid_reg, out_valid_next;
    logic [15:0]    v_valid_reg;
    logic [ROWS-1:0] fb_valid_reg;
    logic           v_rok_reg, fb_rok_reg;
    logic [11:0]    stack_reg [STACK_DEPTH];

    // Payload registers
    in_t            item_reg, item_next;
    logic [15:0]    op_reg, op_next;
    logic [7:0]     vx_reg, vx_next;
    logic [7:0]     vy_reg, vy_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic           flag_reg, flag_next;
    logic           status_reg, status_next;
    logic           draw_reg, draw_next;
    out_t           out_reg, out_next;

    // Memory ports
    logic           mem_we;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [7:0]     mem_wdata, mem_rdata;
    logic           v_we;
    logic [3:0]     v_waddr, v_raddr;
    logic [7:0]     v_wdata, v_rdata, v_rd;
    logic           fb_we, fb_clear;
    logic [ROW_W-1:0] fb_waddr, fb_raddr;
    logic [63:0]    fb_wdata, fb_rdata, fb_rd;
    logic           stk_we;

    // Decode helpers
    logic [3:0]     grp, ox, oy, on;
    logic [7:0]     nn;
    logic [11:0]    nnn, pc_inc2, pc_inc4;
    logic [SPW-1:0] sp_inc, sp_dec;
    logic [16:0]    i_off;
    logic [AW-1:0]  i_addr;
    logic [8:0]     add_sum;
    logic           pressed;
    logic [1:0]     hund;
    logic [6:0]     rem;
    logic [14:0]    tens_prod;
    logic [3:0]     tens, ones;
    logic [63:0]    spr_mask;
    logic [127:0]   spr_wide;
    logic [ROW_W-1:0] draw_row;

    c8ic_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_main (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );
    c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
        .raddr(v_raddr), .rdata(v_rdata)
    );
    c8ic_ram #(.WIDTH(64), .DEPTH(ROWS)) u_frame (
        .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
        .raddr(fb_raddr), .rdata(fb_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Never-written entries read as zero
    assign v_rd  = v_rok_reg ? v_rdata : 8'h00;
    assign fb_rd = fb_rok_reg ? fb_rdata : 64'h0;

    assign grp     = op_reg[15:12];
    assign ox      = op_reg[11:8];
    assign oy      = op_reg[7:4];
    assign on      = op_reg[3:0];
    assign nn      = op_reg[7:0];
    assign nnn     = op_reg[11:0];
    assign pc_inc2 = pc_reg + 12'd2;
    assign pc_inc4 = pc_reg + 12'd4;
    assign sp_inc  = (sp_reg == SP_LAST) ? '0 : sp_reg + SPW'(1);
    assign sp_dec  = (sp_reg == '0) ? SP_LAST : sp_reg - SPW'(1);
    assign i_off   = {1'b0, i_reg} + {13'd0, cnt_reg};
    assign i_addr  = i_off[AW-1:0];
    assign add_sum = {1'b0, vx_reg} + {1'b0, vy_reg};
    assign pressed = (vx_reg[7:4] == 4'h0) && item_reg.key_mask[vx_reg[3:0]];

    // BCD digits by compare and reciprocal multiply
    always_comb
    begin
        logic [7:0] r8;
        if (vx_reg >= 8'd200)
        begin
            hund = 2'd2;
            r8   = vx_reg - 8'd200;
        end
        else if (vx_reg >= 8'd100)
        begin
            hund = 2'd1;
            r8   = vx_reg - 8'd100;
        end
        else
        begin
            hund = 2'd0;
            r8   = vx_reg;
        end
        rem       = r8[6:0];
        tens_prod = ({8'd0, rem} * 15'd205) >> 11;
        tens      = tens_prod[3:0];
        ones      = 4'(rem - ({3'd0, tens} * 7'd10));
    end

    // Sprite byte rotated into its 64-bit row position
    assign spr_wide = {mem_rdata, 56'd0, mem_rdata, 56'd0} >> vx_reg[5:0];
    assign spr_mask = spr_wide[63:0];
    assign draw_row = vy_reg[ROW_W-1:0] + ROW_W'(cnt_reg);

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        i_next         = i_reg;
        sp_next        = sp_reg;
        dt_next        = dt_reg;
        st_next        = st_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        item_next      = item_reg;
        op_next        = op_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        cnt_next       = cnt_reg;
        flag_next      = flag_reg;
        status_next    = status_reg;
        draw_next      = draw_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = i_addr;
        mem_wdata      = vx_reg;
        mem_raddr      = i_addr;
        v_we           = 1'b0;
        v_waddr        = ox;
        v_wdata        = vx_reg;
        v_raddr        = ox;
        fb_we          = 1'b0;
        fb_clear       = 1'b0;
        fb_waddr       = draw_row;
        fb_wdata       = fb_rd ^ spr_mask;
        fb_raddr       = draw_row;
        stk_we         = 1'b0;

        case (state_reg)
            // Write font and zeros through main memory
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = (clr_reg < AW'(FONT_BYTES)) ? font_byte(clr_reg[6:0]) : 8'h00;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == MEM_LAST)
                begin
                    state_next = S_IDLE;
                end
            end

            // Accept a transaction and start its work
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next   = in_data;
                    status_next = 1'b0;
                    draw_next   = 1'b0;
                    op_next     = 16'h0;
                    case (in_data.operation)
                        OP_LOAD:
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = AW'(in_data.address);
                            mem_wdata  = in_data.data_byte;
                            state_next = S_DONE_ROW;
                        end
                        OP_EXEC:
                        begin
                            mem_raddr  = AW'(pc_reg);
                            state_next = S_FETCH1;
                        end
                        OP_TICK:
                        begin
                            if (dt_reg != 8'd0) dt_next = dt_reg - 8'd1;
                            if (st_reg != 8'd0) st_next = st_reg - 8'd1;
                            state_next = S_DONE_ROW;
                        end
                        default:
                        begin
                            fb_raddr   = in_data.address[ROW_W-1:0];
                            state_next = S_DONE_ROW;
                        end
                    endcase
                end
            end

            S_FETCH1:
            begin
                op_next[15:8] = mem_rdata;
                mem_raddr     = AW'({1'b0, pc_reg} + 13'd1);
                state_next    = S_FETCH2;
            end

            S_FETCH2:
            begin
                op_next[7:0] = mem_rdata;
                v_raddr      = op_reg[11:8];
                state_next   = S_RDX;
            end

            // BNNN takes V0 in the second operand slot
            S_RDX:
            begin
                vx_next    = v_rd;
                v_raddr    = (grp == G_JPV) ? 4'h0 : oy;
                state_next = S_RDY;
            end

            S_RDY:
            begin
                vy_next    = v_rd;
                state_next = S_EXEC;
            end

            S_EXEC:
            begin
                state_next = S_DONE_ROW;
                case (grp)
                    G_SYS:
                    begin
                        if (op_reg == OPC_CLS)
                        begin
                            fb_clear  = 1'b1;
                            draw_next = 1'b1;
                            pc_next   = pc_inc2;
                        end
                        else if (op_reg == OPC_RET)
                        begin
                            sp_next = sp_dec;
                            pc_next = stack_reg[sp_dec] + 12'd2;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    G_JP:   pc_next = nnn;
                    G_CALL:
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_inc;
                        pc_next = nnn;
                    end
                    G_SE:   pc_next = (vx_reg == nn) ? pc_inc4 : pc_inc2;
                    G_SNE:  pc_next = (vx_reg != nn) ? pc_inc4 : pc_inc2;
                    G_SER, G_SNER:
                    begin
                        if (on != 4'h0)
                        begin
                            status_next = 1'b1;
                        end
                        else if ((vx_reg == vy_reg) == (grp == G_SER))
                        begin
                            pc_next = pc_inc4;
                        end
                        else
                        begin
                            pc_next = pc_inc2;
                        end
                    end
                    G_LD:
                    begin
                        v_we    = 1'b1;
                        v_wdata = nn;
                        pc_next = pc_inc2;
                    end
                    G_ADD:
                    begin
                        v_we    = 1'b1;
                        v_wdata = vx_reg + nn;
                        pc_next = pc_inc2;
                    end
                    G_ALU:
                    begin
                        v_we    = 1'b1;
                        pc_next = pc_inc2;
                        case (on)
                            ALU_MOV: v_wdata = vy_reg;
                            ALU_OR:  v_wdata = vx_reg | vy_reg;
                            ALU_AND: v_wdata = vx_reg & vy_reg;
                            ALU_XOR: v_wdata = vx_reg ^ vy_reg;
                            ALU_ADD:
                            begin
                                v_wdata    = add_sum[7:0];
                                flag_next  = add_sum[8];
                                state_next = S_WRF;
                            end
                            ALU_SUB:
                            begin
                                v_wdata    = vx_reg - vy_reg;
                                flag_next  = (vx_reg >= vy_reg);
                                state_next = S_WRF;
                            end
                            ALU_SHR:
                            begin
                                v_wdata    = {1'b0, vx_reg[7:1]};
                                flag_next  = vx_reg[0];
                                state_next = S_WRF;
                            end
                            ALU_SBN:
                            begin
                                v_wdata    = vy_reg - vx_reg;
                                flag_next  = (vy_reg >= vx_reg);
                                state_next = S_WRF;
                            end
                            ALU_SHL:
                            begin
                                v_wdata    = {vx_reg[6:0], 1'b0};
                                flag_next  = vx_reg[7];
                                state_next = S_WRF;
                            end
                            default:
                            begin
                                v_we        = 1'b0;
                                pc_next     = pc_reg;
                                status_next = 1'b1;
                            end
                        endcase
                    end
                    G_LDI:
                    begin
                        i_next  = {4'h0, nnn};
                        pc_next = pc_inc2;
                    end
                    G_JPV:  pc_next = {4'h0, vy_reg} + nnn;
                    G_RND:
                    begin
                        v_we    = 1'b1;
                        v_wdata = item_reg.random_byte & nn;
                        pc_next = pc_inc2;
                    end
                    G_DRW:
                    begin
                        cnt_next   = 4'h0;
                        flag_next  = 1'b0;
                        draw_next  = 1'b1;
                        pc_next    = pc_inc2;
                        state_next = (on == 4'h0) ? S_WRF : S_DRAW_RD;
                    end
                    G_KEY:
                    begin
                        if (nn == K_SKP)
                        begin
                            pc_next = pressed ? pc_inc4 : pc_inc2;
                        end
                        else if (nn == K_SKNP)
                        begin
                            pc_next = pressed ? pc_inc2 : pc_inc4;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        pc_next  = pc_inc2;
                        cnt_next = 4'h0;
                        case (nn)
                            F_GDT:
                            begin
                                v_we    = 1'b1;
                                v_wdata = dt_reg;
                            end
                            F_WKEY: ;
                            F_SDT:  dt_next = vx_reg;
                            F_SST:  st_next = vx_reg;
                            F_ADDI: i_next = i_reg + {8'h0, vx_reg};
                            F_FONT: i_next = {10'd0, vx_reg[3:0], 2'b00} + {12'd0, vx_reg[3:0]};
                            F_BCD:  state_next = S_BCD;
                            F_STR:  state_next = S_ST_RD;
                            F_LDR:  state_next = S_LD_RD;
                            default:
                            begin
                                pc_next     = pc_reg;
                                status_next = 1'b1;
                            end
                        endcase
                    end
                endcase
            end

            // Write the flag into VF after the result
            S_WRF:
            begin
                v_we       = 1'b1;
                v_waddr    = 4'hF;
                v_wdata    = {7'd0, flag_reg};
                state_next = S_DONE_ROW;
            end

            // Fetch one sprite byte and its display row
            S_DRAW_RD:
            begin
                state_next = S_DRAW_WR;
            end

            // XOR the byte into the row and note collisions
            S_DRAW_WR:
            begin
                fb_we = 1'b1;
                if ((fb_rd & spr_mask) != 64'h0)
                begin
                    flag_next = 1'b1;
                end
                if (cnt_reg == on - 4'h1)
                begin
                    state_next = S_WRF;
                end
                else
                begin
                    cnt_next   = cnt_reg + 4'h1;
                    state_next = S_DRAW_RD;
                end
            end

            S_BCD:
            begin
                mem_we = 1'b1;
                case (cnt_reg[1:0])
                    2'd0:    mem_wdata = {6'd0, hund};
                    2'd1:    mem_wdata = {4'd0, tens};
                    default: mem_wdata = {4'd0, ones};
                endcase
                cnt_next = cnt_reg + 4'h1;
                if (cnt_reg == 4'h2)
                begin
                    state_next = S_DONE_ROW;
                end
            end

            S_ST_RD:
            begin
                v_raddr    = cnt_reg;
                state_next = S_ST_WR;
            end

            S_ST_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = v_rd;
                cnt_next  = cnt_reg + 4'h1;
                state_next = (cnt_reg == ox) ? S_DONE_ROW : S_ST_RD;
            end

            S_LD_RD:
            begin
                state_next = S_LD_WR;
            end

            S_LD_WR:
            begin
                v_we     = 1'b1;
                v_waddr  = cnt_reg;
                v_wdata  = mem_rdata;
                cnt_next = cnt_reg + 4'h1;
                state_next = (cnt_reg == ox) ? S_DONE_ROW : S_LD_RD;
            end

            // Hold the requested row on the read port, then hand the result over
            default:
            begin
                fb_raddr = item_reg.address[ROW_W-1:0];
                if (!out_valid_reg || out_ready)
                begin
                    out_next.program_counter = pc_reg;
                    out_next.executed_opcode = (item_reg.operation == OP_EXEC) ? op_reg : 16'h0;
                    out_next.status          = status_reg;
                    out_next.draw_flag       = draw_reg;
                    out_next.sound_on        = (st_reg != 8'd0);
                    out_next.display_row     = (item_reg.operation == OP_ROW) ? fb_rd : 64'h0;
                    out_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pc_reg        <= START_RESET;
            i_reg         <= 16'h0;
            sp_reg        <= '0;
            dt_reg        <= 8'h0;
            st_reg        <= 8'h0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            v_valid_reg   <= 16'h0;
            fb_valid_reg  <= '0;
            v_rok_reg     <= 1'b0;
            fb_rok_reg    <= 1'b0;
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                stack_reg[k] <= 12'h0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= cfg_valid ? cfg_data : pc_next;
            i_reg         <= i_next;
            sp_reg        <= sp_next;
            dt_reg        <= dt_next;
            st_reg        <= st_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            v_rok_reg     <= v_valid_reg[v_raddr];
            fb_rok_reg    <= fb_valid_reg[fb_raddr] && !(fb_clear);
            if (v_we)
            begin
                v_valid_reg[v_waddr] <= 1'b1;
            end
            if (fb_clear)
            begin
                fb_valid_reg <= '0;
            end
            else if (fb_we)
            begin
                fb_valid_reg[fb_waddr] <= 1'b1;
            end
            if (stk_we)
            begin
                stack_reg[sp_reg] <= pc_reg;
            end
        end
    end

    // Item payload and result
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        op_reg     <= op_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        cnt_reg    <= cnt_next;
        flag_reg   <= flag_next;
        status_reg <= status_next;
        draw_reg   <= draw_next;
        out_reg    <= out_next;
    end
endmodule
